// ===== design/sha1sh_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 stream hasher.
package sha1sh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] hvec_t;

  localparam hvec_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam word_t K_ROUND0 = 32'h5A827999;
  localparam word_t K_ROUND1 = 32'h6ED9EBA1;
  localparam word_t K_ROUND2 = 32'h8F1BBCDC;
  localparam word_t K_ROUND3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] PHASE1_START = 7'd20;
  localparam logic [6:0] PHASE2_START = 7'd40;
  localparam logic [6:0] PHASE3_START = 7'd60;

  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [4:0] BLOCK_WORDS = 5'd16;
  localparam logic [4:0] LEN_WORD_POS = 5'd14;
  localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_BYTE_END
  } q_op_e;

  typedef struct packed {
    q_op_e      op;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic  push;
    word_t word;
    logic  start;
    logic  reset_h;
  } core_ctl_t;

  typedef struct packed {
    logic done;
  } core_sts_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_WAIT_BLK,
    B_PAD,
    B_ZFILL,
    B_WAIT_PAD,
    B_LEN_HI,
    B_LEN_LO,
    B_WAIT_FIN,
    B_OUT
  } back_state_e;

  function automatic word_t round_k(logic [6:0] rnd);
    word_t k;
    if (rnd < PHASE1_START) begin
      k = K_ROUND0;
    end else if (rnd < PHASE2_START) begin
      k = K_ROUND1;
    end else if (rnd < PHASE3_START) begin
      k = K_ROUND2;
    end else begin
      k = K_ROUND3;
    end
    return k;
  endfunction

  function automatic word_t round_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < PHASE1_START) begin
      f = (b & c) | (~b & d);
    end else if (rnd < PHASE2_START) begin
      f = b ^ c ^ d;
    end else if (rnd < PHASE3_START) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== design/sha1sh_if.sv =====
// Valid/ready channel interfaces for the byte input and the digest output.
interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input end_of_message, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

// ===== design/sha1sh_front.sv =====
// Input front end: classifies items and holds them in a two-entry queue.
module sha1sh_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sha1sh_in_if.sink            in_i,
  output logic                 q_valid_o,
  output sha1sh_pkg::q_entry_t q_entry_o,
  input  logic                 q_pop_i
);
  import sha1sh_pkg::*;

  q_entry_t             ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 push;
  q_entry_t             new_entry;

  assign in_i.ready = (cnt_q != Q_CNT_W'(Q_DEPTH));

  // Items with neither a byte nor an end mark are taken and dropped here.
  always_comb begin
    new_entry.data = in_i.data_byte;
    unique case ({in_i.byte_present, in_i.end_of_message})
      2'b10:   new_entry.op = OP_BYTE;
      2'b01:   new_entry.op = OP_END;
      default: new_entry.op = OP_BYTE_END;
    endcase
    push = in_i.valid && in_i.ready && (in_i.byte_present || in_i.end_of_message);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_entry;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_entry_o = ent_q[rd_ptr_q];

endmodule

// ===== design/sha1sh_core.sv =====
// Compression engine: rolling message schedule, one SHA-1 round per cycle.
module sha1sh_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1sh_pkg::core_ctl_t ctl_i,
  output sha1sh_pkg::core_sts_t sts_o,
  output sha1sh_pkg::hvec_t     h_o
);
  import sha1sh_pkg::*;

  core_state_e st_q, st_d;
  logic [6:0]  rnd_q;
  hvec_t       h_q;
  word_t       w_q [16];
  word_t       wv_q [5];
  logic        round_en;
  logic        add_en;
  logic        shift_en;
  word_t       shift_word;
  word_t       sched;
  word_t       tmp;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      CORE_IDLE:  if (ctl_i.start) st_d = CORE_ROUND;
      CORE_ROUND: if (rnd_q == LAST_ROUND) st_d = CORE_ADD;
      CORE_ADD:   st_d = CORE_IDLE;
      default:    st_d = CORE_IDLE;
    endcase
  end

  always_comb begin
    round_en = 1'b0;
    add_en   = 1'b0;
    unique case (st_q)
      CORE_ROUND: round_en = 1'b1;
      CORE_ADD:   add_en   = 1'b1;
      default:    ;
    endcase
  end

  // The schedule line always holds W[t] at its head; each round appends W[t+16].
  assign sched      = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign shift_en   = ctl_i.push || round_en;
  assign shift_word = round_en ? {sched[30:0], sched[31]} : ctl_i.word;

  assign tmp = {wv_q[0][26:0], wv_q[0][31:27]} + round_f(rnd_q, wv_q[1], wv_q[2], wv_q[3])
             + wv_q[4] + round_k(rnd_q) + w_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= CORE_IDLE;
      rnd_q <= '0;
      h_q   <= H_INIT;
    end else begin
      st_q <= st_d;
      if (round_en && rnd_q != LAST_ROUND) begin
        rnd_q <= rnd_q + 7'd1;
      end else begin
        rnd_q <= '0;
      end
      if (ctl_i.reset_h) begin
        h_q <= H_INIT;
      end else if (add_en) begin
        for (int i = 0; i < 5; i++) begin
          h_q[i] <= h_q[i] + wv_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= shift_word;
    end
    if (ctl_i.start) begin
      for (int i = 0; i < 5; i++) begin
        wv_q[i] <= h_q[i];
      end
    end else if (round_en) begin
      wv_q[0] <= tmp;
      wv_q[1] <= wv_q[0];
      wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
      wv_q[3] <= wv_q[2];
      wv_q[4] <= wv_q[3];
    end
  end

  assign sts_o.done = add_en;
  assign h_o        = h_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> st_q == CORE_IDLE)
    else $error("compression started while the engine was busy");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> st_q == CORE_IDLE)
    else $error("schedule word loaded during a compression");

  a_add_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == CORE_ADD |-> $past(st_q) == CORE_ROUND && $past(rnd_q) == LAST_ROUND)
    else $error("chaining update without a full set of rounds");
`endif

endmodule

// ===== design/sha1sh_back.sv =====
// Back end: byte packing, padding sequence, compression control and digest output.
module sha1sh_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  sha1sh_pkg::q_entry_t q_entry_i,
  output logic                 q_pop_o,
  sha1sh_out_if.source         out_o
);
  import sha1sh_pkg::*;

  back_state_e st_q, st_d;
  word_t       acc_q, acc_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [4:0]  wcnt_q, wcnt_d;
  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q;
  word_t       out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_load;
  logic        out_free;
  core_ctl_t   ctl;
  core_sts_t   sts;
  hvec_t       h;
  logic [5:0]  pos;
  logic        has_byte;
  logic        has_end;
  word_t       byte_word;
  word_t       pad_word;

  function automatic word_t lane_put(word_t acc, logic [1:0] lane, logic [7:0] b);
    word_t w;
    w = (lane == 2'd0) ? '0 : acc;
    case (lane)
      2'd0:    w[31:24] = b;
      2'd1:    w[23:16] = b;
      2'd2:    w[15:8]  = b;
      default: w[7:0]   = b;
    endcase
    return w;
  endfunction

  sha1sh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .h_o    (h)
  );

  assign pos       = bitlen_q[8:3];
  assign has_byte  = (q_entry_i.op == OP_BYTE) || (q_entry_i.op == OP_BYTE_END);
  assign has_end   = (q_entry_i.op == OP_END) || (q_entry_i.op == OP_BYTE_END);
  assign byte_word = lane_put(acc_q, pos[1:0], q_entry_i.data);
  assign pad_word  = lane_put(acc_q, pos[1:0], PAD_BYTE);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: begin
        if (q_valid_i) begin
          if (has_byte && pos == LAST_BYTE_POS) begin
            st_d = B_WAIT_BLK;
          end else if (has_end) begin
            st_d = B_PAD;
          end
        end
      end
      B_WAIT_BLK: begin
        if (sts.done) st_d = has_end ? B_PAD : B_IDLE;
      end
      B_PAD: st_d = B_ZFILL;
      B_ZFILL: begin
        if (wcnt_q == BLOCK_WORDS) begin
          st_d = B_WAIT_PAD;
        end else if (wcnt_q == LEN_WORD_POS) begin
          st_d = B_LEN_HI;
        end
      end
      B_WAIT_PAD: if (sts.done) st_d = B_ZFILL;
      B_LEN_HI:   st_d = B_LEN_LO;
      B_LEN_LO:   st_d = B_WAIT_FIN;
      B_WAIT_FIN: if (sts.done) st_d = B_OUT;
      B_OUT:      if (out_free && idx_q == LAST_DIGEST_IDX) st_d = B_IDLE;
      default:    st_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    ctl      = '0;
    acc_d    = acc_q;
    bitlen_d = bitlen_q;
    wcnt_d   = wcnt_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    unique case (st_q)
      B_IDLE: begin
        if (q_valid_i && has_byte) begin
          acc_d    = byte_word;
          bitlen_d = bitlen_q + 64'd8;
          ctl.word = byte_word;
          ctl.push = (pos[1:0] == 2'd3);
          if (pos == LAST_BYTE_POS) begin
            ctl.start = 1'b1;
          end else if (!has_end) begin
            q_pop_o = 1'b1;
          end
        end
      end
      B_WAIT_BLK: begin
        q_pop_o = sts.done && !has_end;
      end
      B_PAD: begin
        ctl.push = 1'b1;
        ctl.word = pad_word;
        wcnt_d   = {1'b0, pos[5:2]} + 5'd1;
      end
      B_ZFILL: begin
        if (wcnt_q == BLOCK_WORDS) begin
          ctl.start = 1'b1;
        end else if (wcnt_q != LEN_WORD_POS) begin
          ctl.push = 1'b1;
          wcnt_d   = wcnt_q + 5'd1;
        end
      end
      B_WAIT_PAD: begin
        if (sts.done) wcnt_d = '0;
      end
      B_LEN_HI: begin
        ctl.push = 1'b1;
        ctl.word = bitlen_q[63:32];
      end
      B_LEN_LO: begin
        ctl.push  = 1'b1;
        ctl.word  = bitlen_q[31:0];
        ctl.start = 1'b1;
      end
      B_WAIT_FIN: begin
        if (sts.done) idx_d = '0;
      end
      B_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_q == LAST_DIGEST_IDX) begin
            // The last digest word is captured, so the next message starts clean.
            ctl.reset_h = 1'b1;
            bitlen_d    = '0;
            q_pop_o     = 1'b1;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      bitlen_q    <= '0;
      wcnt_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      bitlen_q <= bitlen_d;
      wcnt_q   <= wcnt_d;
      idx_q    <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (out_load) begin
      out_word_q <= h[idx_q];
      out_idx_q  <= idx_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = out_word_q;
  assign out_o.word_index  = out_idx_q;
  assign out_o.last_word   = (out_idx_q == LAST_DIGEST_IDX);

endmodule

// ===== design/sha1_stream_hasher_unit.sv =====
// SHA-1 stream hasher top level: byte input channel, digest word output channel.
// Bytes enter one per transfer and are packed big-endian into 32-bit words that
// feed a 16-word rolling schedule; each full 64-byte block is compressed by an
// engine that runs one round per cycle, 80 rounds followed by the chaining add.
// An end mark adds padding words, two length words, one or two compressions
// and five digest word outputs; the block then returns to the initial chaining
// values. A two-entry queue between the input classifier and the sequencer lets
// input transfers continue, until the queue is full, while a block is being
// compressed.
module sha1_stream_hasher_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1sh_in_if.sink     in_i,
  sha1sh_out_if.source  out_o
);
  import sha1sh_pkg::*;

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  sha1sh_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  sha1sh_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
